/* design/bba_pkg.sv */
`default_nettype none
package bba_pkg;
   localparam int DEFAULT_POOL_UNITS = 1024;
   localparam int ADDR_W = 10;
   localparam int ORDER_W = 4;
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_WALK_RD, S_WALK, S_SPLIT, S_SPLIT2, S_FREE_CHK,
      S_MERGE_RD, S_MERGE, S_OUT
   } state_type;
endpackage
`default_nettype wire

/* design/buddy_block_allocator_top.sv */
// Buddy block allocator.
// req channel: one transaction per request. tdata = {free_address, size_order}
//   (size_order bits 3:0, free_address bits 13:4); tuser = mode (0 alloc, 1 free).
// rsp channel: one transaction per request. tdata = {status, block_address}
//   (block_address bits 9:0, status bits 11:10).
// One request at a time. An allocation reads the block list from unit 0 in
// address order, one block per memory read, then halves the chosen block one
// order per cycle. A free walks the list the same way, then merges with its
// buddy one level at a time, each level with its own memory read. Transaction
// time is set by the single read port of the state memory; a pool with few
// blocks answers quickly.
// After reset, a clearing pass writes every entry of the state memory, one
// entry per cycle, while req_tready is low. The result is held in an output
// register until taken; while rsp stalls, no new request is accepted.
`default_nettype none
module buddy_block_allocator_top
   import bba_pkg::*;
#(
   parameter int POOL_UNITS = DEFAULT_POOL_UNITS
) (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output       logic        req_tready,
   input  wire  logic [15:0] req_tdata,   // size_order[3:0], free_address[13:4]
   input  wire  logic        req_tuser,   // mode
   output       logic        rsp_tvalid,
   input  wire  logic        rsp_tready,
   output       logic [15:0] rsp_tdata    // block_address[9:0], status[11:10]
);
   localparam int PO = $clog2(POOL_UNITS + 1) - 1;      // pool order
   localparam int AW = (PO < 1) ? 1 : PO;
   localparam int SZ = 1 << PO;
   localparam int PW = PO + 1;                          // position width
   localparam int OW = (PO > 15) ? ORDER_W + 1 : ORDER_W; // stored order width

   // one memory: free bit + order per unit
   logic [OW:0]      mem [SZ];
   logic [OW:0]      rd_ff;
   logic [AW-1:0]    ra, wa;
   logic             we;
   logic [OW:0]      wd;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   state_type st_ff, st_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [AW-1:0] best_ff, best_in, addr_ff, addr_in;
   logic [OW-1:0] bo_ff, bo_in;
   logic [ORDER_W-1:0] ro_ff, ro_in;
   logic found_ff, found_in, mode_ff, mode_in;
   logic [ADDR_W-1:0] oaddr_ff, oaddr_in;
   logic [STATUS_W-1:0] ost_ff, ost_in;
   logic [OW-1:0] o;
   logic [AW-1:0] half, bud;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         pos_ff <= '0;
      end else begin
         st_ff <= st_in;
         pos_ff <= pos_in;
      end
      best_ff <= best_in; addr_ff <= addr_in; bo_ff <= bo_in; ro_ff <= ro_in;
      found_ff <= found_in; mode_ff <= mode_in;
      oaddr_ff <= oaddr_in; ost_ff <= ost_in;
   end

   always_comb begin
      o = (rd_ff[OW-1:0] > OW'(PO)) ? OW'(PO) : rd_ff[OW-1:0];
      half = AW'(1) << (bo_ff - OW'(1));
      bud = addr_ff ^ (AW'(1) << bo_ff);
      st_in = st_ff; pos_in = pos_ff; best_in = best_ff; addr_in = addr_ff;
      bo_in = bo_ff; ro_in = ro_ff; found_in = found_ff; mode_in = mode_ff;
      oaddr_in = oaddr_ff; ost_in = ost_ff;
      ra = pos_ff[AW-1:0]; wa = pos_ff[AW-1:0]; we = 1'b0; wd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (st_ff)
         S_CLEAR: begin
            we = 1'b1;
            wd = {1'b1, (pos_ff == '0) ? OW'(PO) : OW'(0)};
            pos_in = pos_ff + PW'(1);
            if (pos_ff == PW'(SZ - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in = req_tuser;
               ro_in = req_tdata[3:0];
               addr_in = AW'(req_tdata[13:4]);
               pos_in = '0; found_in = 1'b0;
               oaddr_in = '0; ost_in = ST_DONE;
               if (!req_tuser && 32'(req_tdata[3:0]) > 32'(PO)) begin
                  ost_in = ST_NOSPACE; st_in = S_OUT;
               end else if (req_tuser && 32'(req_tdata[13:4]) >= 32'(SZ)) begin
                  ost_in = ST_BADFREE; st_in = S_OUT;
               end else begin
                  st_in = S_WALK_RD;
               end
            end
         end
         S_WALK_RD: begin
            if (pos_ff >= PW'(SZ)) begin
               if (mode_ff) begin
                  ost_in = ST_BADFREE; st_in = S_OUT;
               end else if (!found_ff) begin
                  ost_in = ST_NOSPACE; st_in = S_OUT;
               end else begin
                  st_in = S_SPLIT;
               end
            end else if (mode_ff && pos_ff[AW-1:0] == addr_ff) begin
               st_in = S_FREE_CHK;  // ra = addr, data next cycle
            end else begin
               st_in = S_WALK;
            end
         end
         S_WALK: begin
            if (!mode_ff && rd_ff[OW] && o >= OW'(ro_ff) && (!found_ff || o < bo_ff)) begin
               found_in = 1'b1; best_in = pos_ff[AW-1:0]; bo_in = o;
            end
            pos_in = pos_ff + (PW'(1) << o);
            st_in = S_WALK_RD;
         end
         S_SPLIT: begin
            if (bo_ff > OW'(ro_ff)) begin
               we = 1'b1; wa = best_ff + half; wd = {1'b1, bo_ff - OW'(1)};
               bo_in = bo_ff - OW'(1);
            end else begin
               we = 1'b1; wa = best_ff; wd = {1'b0, bo_ff};
               oaddr_in = ADDR_W'(best_ff); ost_in = ST_DONE; st_in = S_OUT;
            end
         end
         S_FREE_CHK: begin
            if (rd_ff[OW]) begin
               ost_in = ST_BADFREE; st_in = S_OUT;
            end else begin
               we = 1'b1; wa = addr_ff; wd = {1'b1, rd_ff[OW-1:0]};
               bo_in = o; st_in = S_MERGE_RD;
            end
         end
         S_MERGE_RD: begin
            ra = bud;
            if (bo_ff >= OW'(PO)) begin
               st_in = S_OUT;
            end else begin
               st_in = S_MERGE;
            end
         end
         S_MERGE: begin
            if (rd_ff[OW] && rd_ff[OW-1:0] == bo_ff) begin
               addr_in = addr_ff & ~(AW'(1) << bo_ff);
               bo_in = bo_ff + OW'(1);
               we = 1'b1; wa = addr_ff & ~(AW'(1) << bo_ff);
               wd = {1'b1, bo_ff + OW'(1)};
               st_in = S_MERGE_RD;
            end else begin
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign rsp_tdata = {4'd0, ost_ff, oaddr_ff};
endmodule
`default_nettype wire

/* design/bba_checker.sv */
`default_nettype none
module bba_checker
   import bba_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[11:10] <= ST_BADFREE) else $error("bad status");
   a_addr0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11:10] != ST_DONE |-> rsp_tdata[9:0] == '0)
      else $error("address on failure");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("overlap");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped");
endmodule
bind buddy_block_allocator_top bba_checker u_chk (.*);
`default_nettype wire
